/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each one expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked only outside reset.
`define ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hw/rtl/crtf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crtf_pkg
// Shared widths, defaults and register indexes of the Catmull-Rom tap filter.
// ----------------------------------------------------------------------------
package crtf_pkg;
  localparam int MAX_TAPS_DEF = 16;
  localparam int SAMPLE_W     = 8;
  localparam int PHASE_W      = 16;
  localparam int TCNT_W       = 5;
  localparam logic [TCNT_W-1:0] TAPS_RST = 5'd4;
  // register index, taken from byte address bit 2
  localparam logic REG_PHASE = 1'b0;
  localparam logic REG_TAPS  = 1'b1;
endpackage
`default_nettype wire

/* hw/rtl/crtf_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crtf_fifo
// Two-entry job queue between the sample front end and the filter engine.
// ----------------------------------------------------------------------------
module crtf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/crtf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crtf_front
// Collects samples into the tap window and queues a job on the last tap.
// ----------------------------------------------------------------------------
module crtf_front #(
  parameter int MAX_TAPS = crtf_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [crtf_pkg::SAMPLE_W-1:0] sample,
  input  logic [crtf_pkg::PHASE_W-1:0]  phase,
  input  logic [crtf_pkg::TCNT_W-1:0]   tap_count,
  input  logic                          full,
  output logic                          push,
  output logic [MAX_TAPS*crtf_pkg::SAMPLE_W + $clog2(MAX_TAPS+1)
                + crtf_pkg::PHASE_W - 1:0] job
);
  import crtf_pkg::*;

  localparam int TAP_W = $clog2(MAX_TAPS + 1);
  localparam int IDX_W = $clog2(MAX_TAPS);
  localparam int CMP_W = (TAP_W > TCNT_W) ? TAP_W : TCNT_W;

  logic [SAMPLE_W-1:0]          window [MAX_TAPS];
  logic [TAP_W-1:0]             tap_index;
  logic [TAP_W-1:0]             taps;
  logic [TAP_W-1:0]             pos;
  logic [CMP_W-1:0]             tc_ext;
  logic                         take;
  logic                         last;
  logic [MAX_TAPS*SAMPLE_W-1:0] win_flat;

  assign busy = full;
  assign take = start && !busy;

  always_comb begin
    tc_ext = CMP_W'(tap_count);
    if (tc_ext < CMP_W'(2)) begin
      taps = TAP_W'(2);
    end else if (tc_ext > CMP_W'(MAX_TAPS)) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = TAP_W'(tc_ext);
    end
    // count lowered mid-window: clamp to the last tap
    pos  = (tap_index >= taps) ? taps - TAP_W'(1) : tap_index;
    last = ({1'b0, pos} + (TAP_W+1)'(1)) >= {1'b0, taps};
  end

  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      win_flat[k*SAMPLE_W +: SAMPLE_W] = (TAP_W'(k) == pos) ? sample : window[k];
    end
  end

  assign push = take && last;
  assign job  = {phase, taps, win_flat};

  always_ff @(posedge clk) begin
    if (take) begin
      window[pos[IDX_W-1:0]] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_index <= '0;
    end else if (take) begin
      tap_index <= last ? '0 : pos + TAP_W'(1);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/crtf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crtf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crtf_div #(
  parameter int N_W = 64,
  parameter int D_W = 40
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [N_W-1:0] quotient
);
  localparam int CNT_W = $clog2(N_W);

  logic [N_W-1:0]   quot;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [D_W:0]     shifted;
  logic [D_W:0]     diff;
  logic             ge;

  assign shifted  = {rem, quot[N_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = shifted >= {1'b0, dvs};
  assign busy     = run;
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (run) begin
      quot <= {quot[N_W-2:0], ge};
      rem  <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(N_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/crtf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crtf_back
// Filter engine: per-tap weights, normalization by division, MAC and rounding.
// ----------------------------------------------------------------------------
module crtf_back #(
  parameter int MAX_TAPS = crtf_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  logic [MAX_TAPS*crtf_pkg::SAMPLE_W + $clog2(MAX_TAPS+1)
                + crtf_pkg::PHASE_W - 1:0] job,
  output logic                          pop,
  output logic [crtf_pkg::SAMPLE_W-1:0] pixel,
  output logic                          valid
);
  import crtf_pkg::*;
  `include "assert_macros.svh"

  localparam int TAP_W = $clog2(MAX_TAPS + 1);
  localparam int IDX_W = $clog2(MAX_TAPS);
  localparam int W_W   = 34;
  localparam int TOT_W = W_W + IDX_W + 1;
  localparam int N_W   = 64;
  localparam int D_W   = TOT_W;
  localparam int AD_W  = TAP_W + 18;
  localparam int NUM_W = 37;
  localparam int MAC_W = 32 + SAMPLE_W + 1;
  localparam int ACC_W = MAC_W + IDX_W + 1;
  localparam int WIN_W = MAX_TAPS * SAMPLE_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_XDIV  = 4'd1;
  localparam logic [3:0] S_XWAIT = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_CUBE  = 4'd4;
  localparam logic [3:0] S_WGT   = 4'd5;
  localparam logic [3:0] S_CDIV  = 4'd6;
  localparam logic [3:0] S_CWAIT = 4'd7;
  localparam logic [3:0] S_MAC   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]              state;
  logic [TAP_W-1:0]        i;
  logic [TAP_W-1:0]        taps;
  logic [PHASE_W-1:0]      phase;
  logic [SAMPLE_W-1:0]     smp [MAX_TAPS];
  logic signed [W_W-1:0]   wgt [MAX_TAPS];
  logic [30:0]             x;
  logic [31:0]             x2;
  logic [32:0]             x3;
  logic signed [TOT_W-1:0] total;
  logic signed [31:0]      c;
  logic signed [ACC_W-1:0] acc;

  logic [IDX_W-1:0]        ix;
  logic                    last_tap;
  logic [TAP_W-1:0]        half;
  logic signed [TAP_W:0]   nd;
  logic signed [AD_W-1:0]  dval;
  logic [AD_W-1:0]         ad;
  logic [61:0]             prod2;
  logic [62:0]             prod3;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] num_adj;
  logic signed [W_W-1:0]   w_new;
  logic [W_W-1:0]          wabs;
  logic [TOT_W-1:0]        tabs;
  logic                    neg;
  logic signed [31:0]      c_new;
  logic signed [MAC_W-1:0] mac;
  logic [ACC_W-1:0]        rsum;
  logic [SAMPLE_W-1:0]     pix_new;

  logic                    div_start;
  logic [N_W-1:0]          div_dividend;
  logic [D_W-1:0]          div_divisor;
  logic                    div_busy;
  logic                    div_done;
  logic [N_W-1:0]          div_q;

  assign ix       = i[IDX_W-1:0];
  assign last_tap = ({1'b0, i} + (TAP_W+1)'(1)) == {1'b0, taps};
  assign pop      = (state == S_IDLE) && job_valid;

  // tap offset: (i + 1 - taps/2) * 2^16 - phase
  always_comb begin
    half = taps >> 1;
    nd   = $signed({1'b0, i}) + (TAP_W+1)'(1) - $signed({1'b0, half});
    dval = $signed({nd[TAP_W], nd, 16'b0}) - $signed({{(AD_W-PHASE_W){1'b0}}, phase});
    ad   = dval[AD_W-1] ? AD_W'(-dval) : AD_W'(dval);
  end

  assign prod2 = 62'(x) * 62'(x);
  assign prod3 = 63'(x2) * 63'(x);

  always_comb begin
    if (!x[30]) begin
      num = 3 * $signed({4'b0, x3}) - 5 * $signed({5'b0, x2})
            + $signed(NUM_W'(64'h8000_0000));
    end else begin
      num = -$signed({4'b0, x3}) + 5 * $signed({5'b0, x2})
            - 8 * $signed({6'b0, x}) + $signed(NUM_W'(64'h1_0000_0000));
    end
    // halve, rounding toward zero
    num_adj = num + $signed({{(NUM_W-1){1'b0}}, num[NUM_W-1]});
    w_new   = num_adj[W_W:1];
  end

  always_comb begin
    wabs = wgt[ix][W_W-1] ? W_W'(-wgt[ix]) : W_W'(wgt[ix]);
    tabs = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);
    neg  = wgt[ix][W_W-1] ^ total[TOT_W-1];
    if (!neg) begin
      c_new = (|div_q[N_W-1:31]) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]);
    end else begin
      c_new = (|div_q[N_W-1:31]) ? $signed(32'h8000_0000) : -$signed(div_q[31:0]);
    end
    mac = c * $signed({1'b0, smp[ix]});
  end

  always_comb begin
    rsum = ACC_W'(acc) + ACC_W'(64'd536879104);
    if (acc[ACC_W-1]) begin
      pix_new = '0;
    end else if (|rsum[ACC_W-1:38]) begin
      pix_new = '1;
    end else begin
      pix_new = rsum[37:30];
    end
  end

  assign div_start    = (state == S_XDIV) || ((state == S_CDIV) && (total != '0));
  assign div_dividend = (state == S_XDIV) ? N_W'({ad, 18'b0}) : N_W'({wabs, 30'b0});
  assign div_divisor  = (state == S_XDIV) ? D_W'(taps) : D_W'(tabs);

  crtf_div #(
    .N_W(N_W),
    .D_W(D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (job_valid) begin
          for (int k = 0; k < MAX_TAPS; k++) begin
            smp[k] <= job[k*SAMPLE_W +: SAMPLE_W];
          end
          taps  <= job[WIN_W +: TAP_W];
          phase <= job[WIN_W + TAP_W +: PHASE_W];
          total <= '0;
        end
      end
      S_XWAIT: begin
        if (div_done) begin
          x <= div_q[30:0];
          if (|div_q[N_W-1:31]) begin
            wgt[ix] <= '0;  // outside the kernel support
          end
        end
      end
      S_SQ:   x2 <= prod2[61:30];
      S_CUBE: x3 <= prod3[62:30];
      S_WGT: begin
        wgt[ix] <= w_new;
        total   <= total + TOT_W'(w_new);
      end
      S_CDIV: begin
        if (total == '0) acc <= '0;
      end
      S_CWAIT: begin
        if (div_done) c <= c_new;
      end
      S_MAC: acc <= acc + ACC_W'(mac);
      S_OUT: pixel <= pix_new;
      default: ;
    endcase
    if (state == S_XWAIT && div_done && (i == '0)) begin
      acc <= '0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            i     <= '0;
            state <= S_XDIV;
          end
        end
        S_XDIV: state <= S_XWAIT;
        S_XWAIT: begin
          if (div_done) begin
            if (|div_q[N_W-1:31]) begin
              i     <= last_tap ? '0 : i + TAP_W'(1);
              state <= last_tap ? S_CDIV : S_XDIV;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_SQ:   state <= S_CUBE;
        S_CUBE: state <= S_WGT;
        S_WGT: begin
          i     <= last_tap ? '0 : i + TAP_W'(1);
          state <= last_tap ? S_CDIV : S_XDIV;
        end
        S_CDIV: state <= (total == '0) ? S_OUT : S_CWAIT;
        S_CWAIT: begin
          if (div_done) state <= S_MAC;
        end
        S_MAC: begin
          i     <= last_tap ? '0 : i + TAP_W'(1);
          state <= last_tap ? S_OUT : S_CDIV;
        end
        S_OUT: begin
          valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NR(a_valid_pulse, valid |=> !valid, "result strobe held longer than one cycle")
  `ASSERT_NR(a_div_free, div_start |-> !div_busy, "divider restarted while running")
  `ASSERT_NR(a_div_done_wait, div_done |-> (state == S_XWAIT || state == S_CWAIT),
             "divider finished with no one waiting")
  `ASSERT_ALWAYS(a_rst_quiet, rst |=> !valid, "result strobe right after reset")
endmodule
`default_nettype wire

/* hw/rtl/catmull_rom_tap_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Samples are taken one per cycle while busy is low; busy rises only when the job queue is full.
// After the last tap of a window its job is queued; the engine takes it when idle and runs the
// shared 64-step divider once per tap for x and, unless the weights sum to zero, once per tap
// for the coefficient; a tap outside the kernel support skips the square, cube and weight states.
// The engine takes a new window only after strobing the last output; the receiver cannot stall.
// Reset clears the tap index, the queue and the engine; phase = 0, tap_count = 4.
// ----------------------------------------------------------------------------
// catmull_rom_tap_filter
// Catmull-Rom resampling filter: one output byte per window of byte samples.
// ----------------------------------------------------------------------------
module catmull_rom_tap_filter #(
  parameter int MAX_TAPS = crtf_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [crtf_pkg::SAMPLE_W-1:0] sample,
  output logic [crtf_pkg::SAMPLE_W-1:0] pixel,
  output logic                          valid,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import crtf_pkg::*;

  localparam int JOB_W = MAX_TAPS*SAMPLE_W + $clog2(MAX_TAPS+1) + PHASE_W;

  logic [PHASE_W-1:0] phase;
  logic [TCNT_W-1:0]  tap_count;
  logic               push;
  logic               full;
  logic               pop;
  logic               empty;
  logic [JOB_W-1:0]   job_in;
  logic [JOB_W-1:0]   job_out;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      tap_count <= TAPS_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_PHASE: phase     <= pwdata[PHASE_W-1:0];
        REG_TAPS:  tap_count <= pwdata[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PHASE: prdata = 32'(phase);
      REG_TAPS:  prdata = 32'(tap_count);
      default:   prdata = '0;
    endcase
  end

  crtf_front #(
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sample    (sample),
    .phase     (phase),
    .tap_count (tap_count),
    .full      (full),
    .push      (push),
    .job       (job_in)
  );

  crtf_fifo #(
    .WIDTH(JOB_W)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .full  (full),
    .pop   (pop),
    .dout  (job_out),
    .empty (empty)
  );

  crtf_back #(
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!empty),
    .job       (job_out),
    .pop       (pop),
    .pixel     (pixel),
    .valid     (valid)
  );
endmodule
`default_nettype wire
